>>> rtl/gef_pkg.sv
// shared types, codes and helpers for the glob entry filter
`default_nettype none

package gef_pkg;

  // pattern store depth the top level defaults to
  localparam int unsigned PATTERN_DEPTH_DEFAULT = 64;

  // widths of the configuration port
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  // characters with a meaning of their own
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_QMARK  = 8'h3F;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  typedef enum logic {
    OP_PAT_WRITE = 1'b0,
    OP_NAME_CHAR = 1'b1
  } gef_op_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN_LENGTH = 3'd0,
    CFG_CASE_SENSITIVE = 3'd1,
    CFG_TYPE_FILTER    = 3'd2,
    CFG_MIN_SIZE       = 3'd3,
    CFG_MAX_SIZE       = 3'd4
  } gef_cfg_e;

  typedef struct packed {
    gef_op_e     op;
    logic [5:0]  pattern_index;
    logic [7:0]  char_value;
    logic        last_char;
    logic        entry_type;
    logic [31:0] entry_size;
  } gef_in_t;

  typedef struct packed {
    logic matched;
    logic name_ok;
    logic type_ok;
    logic size_ok;
    logic dot_entry;
  } gef_out_t;

  // one step handed to the matcher
  typedef struct packed {
    logic       pat_we;
    logic       name_step;
    logic       last;
    logic [5:0] pattern_index;
    logic [7:0] char_value;
  } gef_step_t;

  // what the matcher reports for the step in flight
  typedef struct packed {
    logic name_ok;
    logic dot_entry;
  } gef_stat_t;

  // fold A-Z to lower case unless compares are exact
  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic exact);
    logic [7:0] r;
    r = c;
    if (!exact && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/gef_nfa.sv
// pattern store, nfa active set and dot-name tracker
`default_nettype none

module gef_nfa import gef_pkg::*; #(
  parameter int unsigned PatternDepth = PATTERN_DEPTH_DEFAULT
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire gef_step_t step_i,
  input  wire logic [5:0] pattern_length_i,
  input  wire logic      case_sensitive_i,
  output gef_stat_t      stat_o
);

  localparam int unsigned MaxLen = (PatternDepth > 63) ? 63 : PatternDepth;
  localparam int unsigned AW     = MaxLen + 1;
  localparam int unsigned NW     = $clog2(AW);
  localparam int unsigned IdxW   = $clog2(PatternDepth);

  typedef enum logic [3:0] {
    DOT_NONE  = 4'b0001,
    DOT_ONE   = 4'b0010,
    DOT_TWO   = 4'b0100,
    DOT_OTHER = 4'b1000
  } dot_e;

  logic [7:0]    pat_q [PatternDepth];
  logic [AW-1:0] active_q, active_d;
  dot_e          dot_q, dot_d, dot_nx;

  logic [NW-1:0] n_eff;
  logic [AW-1:0] pos_mask, pass_v, s_cl, t_raw, t_cl;
  logic [7:0]    fc;

  // star runs pass activity forward: log-depth prefix over the positions
  function automatic logic [AW-1:0] closure(input logic [AW-1:0] s,
                                            input logic [AW-1:0] p_in);
    logic [AW-1:0] x;
    logic [AW-1:0] p;
    x = s;
    p = p_in;
    for (int unsigned d = 1; d < AW; d = d * 2) begin
      x = x | ((x & p) << d);
      p = p & (p >> d);
    end
    return x;
  endfunction

  always_comb begin
    n_eff = (pattern_length_i > 6'(MaxLen)) ? NW'(MaxLen) : NW'(pattern_length_i);
    fc    = fold_char(step_i.char_value, case_sensitive_i);
    pos_mask = '0;
    pass_v   = '0;
    for (int unsigned j = 0; j < AW; j++) begin
      pos_mask[j] = (NW'(j) <= n_eff);
    end
    for (int unsigned i = 0; i < AW - 1; i++) begin
      pass_v[i] = (NW'(i) < n_eff) && (pat_q[i] == CHAR_STAR);
    end
    s_cl  = closure(active_q & pos_mask, pass_v);
    t_raw = '0;
    for (int unsigned i = 0; i < AW - 1; i++) begin
      if (s_cl[i] && (NW'(i) < n_eff)) begin
        if (pat_q[i] == CHAR_STAR) begin
          t_raw[i] = 1'b1;
        end else if (pat_q[i] == CHAR_QMARK || fold_char(pat_q[i], case_sensitive_i) == fc) begin
          t_raw[i+1] = 1'b1;
        end
      end
    end
    t_cl = closure(t_raw, pass_v);
  end

  always_comb begin
    unique case (dot_q)
      DOT_NONE: dot_nx = (step_i.char_value == CHAR_DOT) ? DOT_ONE : DOT_OTHER;
      DOT_ONE:  dot_nx = (step_i.char_value == CHAR_DOT) ? DOT_TWO : DOT_OTHER;
      default:  dot_nx = DOT_OTHER;
    endcase
  end

  always_comb begin
    active_d = active_q;
    dot_d    = dot_q;
    if (step_i.name_step) begin
      active_d = step_i.last ? AW'(1) : t_cl;
      dot_d    = step_i.last ? DOT_NONE : dot_nx;
    end
  end

  assign stat_o.name_ok   = (n_eff == '0) || t_cl[n_eff];
  assign stat_o.dot_entry = (dot_nx == DOT_ONE) || (dot_nx == DOT_TWO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= AW'(1);
      dot_q    <= DOT_NONE;
    end else begin
      active_q <= active_d;
      dot_q    <= dot_d;
    end
  end

  // writes beyond the store depth are dropped
  always_ff @(posedge clk_i) begin
    if (step_i.pat_we && (7'(step_i.pattern_index) < 7'(PatternDepth))) begin
      pat_q[step_i.pattern_index[IdxW-1:0]] <= step_i.char_value;
    end
  end

endmodule

`default_nettype wire

>>> rtl/glob_entry_filter_top.sv
// top level of the glob entry filter: handshakes, configuration and result checks
`default_nettype none

// Glob entry filter. Load a glob pattern ('*' any run, '?' one character)
// with pattern-write beats, then stream each entry name one byte per beat;
// the beat that carries the last byte also carries the entry type and size
// and yields exactly one result beat with the name, type and size verdicts.
// Every other beat yields nothing. The block takes one input beat per clock
// cycle: a beat sits in the input register, where the whole nfa
// update over all pattern positions is done in a single step, and a last
// byte then moves into the result register. The only stall is a last byte
// that finds the result register still full and not being drained in that
// cycle. Names "." and ".." never match; pattern length 0 disables the name
// test. Configuration writes are taken at any cycle (ready is always high)
// and must only be issued while no beat is in flight.

module glob_entry_filter_top import gef_pkg::*; #(
  parameter int unsigned PatternDepth = PATTERN_DEPTH_DEFAULT
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // input beats
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire gef_in_t                in_data_i,
  // result beats
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output gef_out_t                    out_data_o,
  // configuration writes
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  // configuration registers
  logic [5:0]  pattern_length_q;
  logic        case_sensitive_q;
  logic [1:0]  type_filter_q;
  logic [31:0] min_size_q;
  logic [31:0] max_size_q;

  // input register
  gef_in_t   s1_q;
  logic      s1_valid_q;
  logic      s1_has_result;
  logic      s1_go;

  // result register
  gef_out_t  out_q, out_d;
  logic      out_valid_q, out_valid_d;

  gef_step_t step;
  gef_stat_t stat;
  logic      type_ok, size_ok;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_length_q <= '0;
      case_sensitive_q <= 1'b0;
      type_filter_q    <= 2'b11;   // any type
      min_size_q       <= '0;
      max_size_q       <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data_i[5:0];
        CFG_CASE_SENSITIVE: case_sensitive_q <= cfg_data_i[0];
        CFG_TYPE_FILTER:    type_filter_q    <= cfg_data_i[1:0];
        CFG_MIN_SIZE:       min_size_q       <= cfg_data_i;
        CFG_MAX_SIZE:       max_size_q       <= cfg_data_i;
        default: ;          // unused indexes are ignored
      endcase
    end
  end

  // only a last name byte needs room in the result register
  assign s1_has_result = (s1_q.op == OP_NAME_CHAR) && s1_q.last_char;
  assign s1_go         = s1_valid_q && (!s1_has_result || !out_valid_q || out_ready_i);
  assign in_ready_o    = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_data_i;
    end
  end

  // the matcher commits its state only when the beat leaves the input register
  always_comb begin
    step.pat_we        = s1_go && (s1_q.op == OP_PAT_WRITE);
    step.name_step     = s1_go && (s1_q.op == OP_NAME_CHAR);
    step.last          = s1_q.last_char;
    step.pattern_index = s1_q.pattern_index;
    step.char_value    = s1_q.char_value;
  end

  gef_nfa #(
    .PatternDepth(PatternDepth)
  ) u_nfa (
    .clk_i,
    .rst_ni,
    .step_i           (step),
    .pattern_length_i (pattern_length_q),
    .case_sensitive_i (case_sensitive_q),
    .stat_o           (stat)
  );

  // type filter: a negative code passes everything
  assign type_ok = type_filter_q[1] || (s1_q.entry_type == type_filter_q[0]);

  // size limits apply to files only; a zero limit is off
  always_comb begin
    size_ok = 1'b1;
    if (!s1_q.entry_type) begin
      if ((min_size_q != '0) && (s1_q.entry_size < min_size_q)) begin
        size_ok = 1'b0;
      end
      if ((max_size_q != '0) && (s1_q.entry_size > max_size_q)) begin
        size_ok = 1'b0;
      end
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_go && s1_has_result) begin
      out_valid_d       = 1'b1;
      out_d.name_ok     = stat.name_ok;
      out_d.type_ok     = type_ok;
      out_d.size_ok     = size_ok;
      out_d.dot_entry   = stat.dot_entry;
      out_d.matched     = stat.name_ok && type_ok && size_ok && !stat.dot_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
